// ----- hdl/reply_slot_ring_matcher_top_macros.svh -----
// Assertion macros for the reply slot ring matcher.
// Used by reply_slot_ring_matcher_top; expects clk and rst_n in scope.
`ifndef REPLY_SLOT_RING_MATCHER_TOP_MACROS_SVH
`define REPLY_SLOT_RING_MATCHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RSRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RSRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSRM_ASSERT_IMP(lbl, ante, cons, msg)
`define RSRM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/rsrm_pkg.sv -----
// Shared constants and types of the reply slot ring matcher.
// No dependencies.
package rsrm_pkg;

  // slot tags
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // item commands
  localparam logic [2:0] CMD_BEGIN  = 3'd0;
  localparam logic [2:0] CMD_BYTE   = 3'd1;
  localparam logic [2:0] CMD_REPLY  = 3'd2;
  localparam logic [2:0] CMD_CLOSE  = 3'd3;
  localparam logic [2:0] CMD_RECV   = 3'd4;
  localparam logic [2:0] CMD_CANCEL = 3'd5;

  // result status
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_IGN  = 2'd2;
  localparam logic [1:0] STAT_DROP = 2'd3;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    logic [6:0] slot_index;
    logic       reply_valid;
    logic [7:0] reply_data;
    logic       unexpected_byte;
    logic       overrun;
  } rsrm_res_t;

endpackage

// ----- hdl/rsrm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rsrm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/reply_slot_ring_matcher_top.sv -----
// Reply slot ring matcher: per-port rings of slot tags in one RAM, sequenced FSM.
// Steps: begin, append and rejected items go from idle through dispatch to done;
// receive walks from the receive position; cancel reduces the slot, then walks back marking.
// Flow: one item in flight; a new item is taken only in idle, and done holds while a result waits.
// Reset: clearing pass sets every tag to command, 2**(PIW+PW) tags (512 by default), in_tready low.
// Depends on rsrm_pkg, rsrm_ram and reply_slot_ring_matcher_top_macros.svh.
`include "reply_slot_ring_matcher_top_macros.svh"

module reply_slot_ring_matcher_top
  import rsrm_pkg::*;
#(
  parameter int RING_DEPTH = 128,
  parameter int PORT_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // port[1:0], data[9:2], slot[16:10], zero[23:17]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // slot_index[6:0], reply_valid[7], reply_data[15:8],
                                  // unexpected_byte[16], overrun[17], zero[23:18]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int PW   = $clog2(RING_DEPTH);
  localparam int PIW  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int NP   = 1 << PIW;
  localparam int AW   = PIW + PW;
  localparam int SKW  = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0]  LAST   = PW'(RING_DEPTH - 1);
  localparam logic [6:0]     DEPTH7 = 7'(RING_DEPTH);
  localparam logic [SKW-1:0] SKIPS  = SKW'(RING_DEPTH);

  // state codes
  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DISP    = 4'd2;
  localparam logic [3:0] ST_RX_CHK  = 4'd3;
  localparam logic [3:0] ST_RSY_CHK = 4'd4;
  localparam logic [3:0] ST_CAN_MOD = 4'd5;
  localparam logic [3:0] ST_CAN_CHK = 4'd6;
  localparam logic [3:0] ST_DONE    = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  // latched item
  logic [2:0] cmd_r, cmd_nxt;
  logic [1:0] port_r, port_nxt;
  logic [7:0] data_r, data_nxt;
  logic [6:0] slot_r, slot_nxt;

  // walk state
  logic [SKW-1:0] skip_r, skip_nxt;
  logic [6:0]     red_r, red_nxt;
  logic [PW-1:0]  walk_r, walk_nxt;

  rsrm_res_t res_r, res_nxt;
  rsrm_res_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  // per-port pointers
  logic [PW-1:0] tx_pos_r [NP];
  logic [PW-1:0] tx_pos_nxt [NP];
  logic [PW-1:0] rx_pos_r [NP];
  logic [PW-1:0] rx_pos_nxt [NP];
  logic [PW-1:0] sv_pos_r [NP];
  logic [PW-1:0] sv_pos_nxt [NP];
  logic [7:0]    tx_lap_r [NP];
  logic [7:0]    tx_lap_nxt [NP];
  logic [7:0]    rx_lap_r [NP];
  logic [7:0]    rx_lap_nxt [NP];
  logic [7:0]    sv_lap_r [NP];
  logic [7:0]    sv_lap_nxt [NP];
  logic          failed_r [NP];
  logic          failed_nxt [NP];

  // tag RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [1:0]    ram_rdata;

  rsrm_ram #(
    .WIDTH (2),
    .DEPTH (1 << AW)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // current port view
  logic [PIW-1:0] pidx;
  logic           port_bad;
  logic [PW-1:0]  cur_tx, cur_rx, adv_pos, tx_np, nw;
  logic [7:0]     cur_tlap, cur_rlap, adv_lap, tx_nl;
  logic           adv_over, do_adv;
  logic [SKW-1:0] skip_inc;
  logic [1:0]     app_kind;

  assign pidx     = PIW'(port_r);
  assign port_bad = int'(port_r) >= PORT_COUNT;
  assign cur_tx   = tx_pos_r[pidx];
  assign cur_rx   = rx_pos_r[pidx];
  assign cur_tlap = tx_lap_r[pidx];
  assign cur_rlap = rx_lap_r[pidx];

  // receive advance and overrun test
  assign adv_pos  = (cur_rx == LAST) ? '0 : cur_rx + 1'b1;
  assign adv_lap  = (cur_rx == LAST) ? cur_rlap + 8'd1 : cur_rlap;
  assign adv_over = ((adv_lap == cur_tlap) && (adv_pos > cur_tx)) || (adv_lap > cur_tlap);

  // transmit advance
  assign tx_np = (cur_tx == LAST) ? '0 : cur_tx + 1'b1;
  assign tx_nl = (cur_tx == LAST) ? cur_tlap + 8'd1 : cur_tlap;

  assign skip_inc = skip_r + 1'b1;
  assign nw       = (walk_r == '0) ? LAST : walk_r - 1'b1;

  // tag appended for each transmit command
  always_comb begin
    unique case (cmd_r)
      CMD_REPLY: app_kind = KIND_REPLY;
      CMD_CLOSE: app_kind = KIND_END;
      default:   app_kind = KIND_CMD;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    port_nxt      = port_r;
    data_nxt      = data_r;
    slot_nxt      = slot_r;
    skip_nxt      = skip_r;
    red_nxt       = red_r;
    walk_nxt      = walk_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    tx_pos_nxt    = tx_pos_r;
    rx_pos_nxt    = rx_pos_r;
    sv_pos_nxt    = sv_pos_r;
    tx_lap_nxt    = tx_lap_r;
    rx_lap_nxt    = rx_lap_r;
    sv_lap_nxt    = sv_lap_r;
    failed_nxt    = failed_r;
    ram_we        = 1'b0;
    ram_waddr     = {pidx, cur_rx};
    ram_wdata     = KIND_END;
    ram_raddr     = {pidx, cur_rx};
    do_adv        = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = KIND_CMD;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          port_nxt  = in_tdata[1:0];
          data_nxt  = in_tdata[9:2];
          slot_nxt  = in_tdata[16:10];
          skip_nxt  = '0;
          res_nxt   = '0;
          state_nxt = ST_DISP;
        end
      end

      ST_DISP: begin
        state_nxt = ST_DONE;
        if (port_bad) begin
          res_nxt.status = STAT_IGN;
        end else begin
          unique case (cmd_r) inside
            CMD_BEGIN: begin
              sv_pos_nxt[pidx]   = cur_tx;
              sv_lap_nxt[pidx]   = cur_tlap;
              failed_nxt[pidx]   = 1'b0;
              res_nxt.slot_index = 7'(cur_tx);
            end
            CMD_BYTE, CMD_REPLY, CMD_CLOSE: begin
              res_nxt.slot_index = 7'(cur_tx);
              if (failed_r[pidx]) begin
                res_nxt.status = STAT_IGN;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = {pidx, cur_tx};
                ram_wdata = app_kind;
                // ring full: roll back to the saved position
                if (tx_np == cur_rx) begin
                  tx_pos_nxt[pidx] = sv_pos_r[pidx];
                  tx_lap_nxt[pidx] = sv_lap_r[pidx];
                  failed_nxt[pidx] = 1'b1;
                  res_nxt.status   = STAT_FULL;
                end else begin
                  tx_pos_nxt[pidx] = tx_np;
                  tx_lap_nxt[pidx] = tx_nl;
                end
              end
            end
            CMD_RECV: begin
              ram_raddr = {pidx, cur_rx};
              state_nxt = ST_RX_CHK;
            end
            CMD_CANCEL: begin
              red_nxt   = slot_r;
              state_nxt = ST_CAN_MOD;
            end
            default: begin
              res_nxt.status = STAT_IGN;
            end
          endcase
        end
      end

      // match the byte to the tag at the receive position
      ST_RX_CHK: begin
        ram_raddr = {pidx, adv_pos};
        case (ram_rdata)
          KIND_CMD: begin
            ram_we = 1'b1;
            do_adv = 1'b1;
            if (data_r != 8'd0) begin
              res_nxt.unexpected_byte = 1'b1;
              state_nxt               = ST_RSY_CHK;
            end else begin
              res_nxt.slot_index = 7'(cur_rx);
              state_nxt          = ST_DONE;
            end
          end
          KIND_REPLY: begin
            ram_we              = 1'b1;
            do_adv              = 1'b1;
            res_nxt.slot_index  = 7'(cur_rx);
            res_nxt.reply_valid = 1'b1;
            res_nxt.reply_data  = data_r;
            state_nxt           = ST_DONE;
          end
          default: begin
            // end slot: skip, bounded to one lap
            do_adv   = 1'b1;
            skip_nxt = skip_inc;
            if (skip_inc == SKIPS) begin
              res_nxt.status     = STAT_DROP;
              res_nxt.slot_index = 7'(adv_pos);
              state_nxt          = ST_DONE;
            end
          end
        endcase
      end

      // resync: mark slots end up to and including the next end mark
      ST_RSY_CHK: begin
        ram_raddr = {pidx, adv_pos};
        do_adv    = 1'b1;
        if (ram_rdata != KIND_END) begin
          ram_we = 1'b1;
        end else begin
          res_nxt.slot_index = 7'(cur_rx);
          state_nxt          = ST_DONE;
        end
      end

      // reduce the cancel slot into the ring
      ST_CAN_MOD: begin
        if (int'(red_r) >= RING_DEPTH) begin
          red_nxt = red_r - DEPTH7;
        end else begin
          walk_nxt           = PW'(red_r);
          res_nxt.slot_index = red_r;
          ram_raddr          = {pidx, PW'(red_r)};
          state_nxt          = ST_CAN_CHK;
        end
      end

      // walk backward marking slots end
      ST_CAN_CHK: begin
        ram_raddr = {pidx, nw};
        if (ram_rdata != KIND_END) begin
          ram_we    = 1'b1;
          ram_waddr = {pidx, walk_r};
          walk_nxt  = nw;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // apply one receive advance
    if (do_adv) begin
      rx_pos_nxt[pidx] = adv_pos;
      rx_lap_nxt[pidx] = adv_lap;
      res_nxt.overrun  = res_r.overrun | adv_over;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NP; i++) begin
        tx_pos_r[i] <= '0;
        rx_pos_r[i] <= '0;
        sv_pos_r[i] <= '0;
        tx_lap_r[i] <= '0;
        rx_lap_r[i] <= '0;
        sv_lap_r[i] <= '0;
        failed_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      tx_pos_r    <= tx_pos_nxt;
      rx_pos_r    <= rx_pos_nxt;
      sv_pos_r    <= sv_pos_nxt;
      tx_lap_r    <= tx_lap_nxt;
      rx_lap_r    <= rx_lap_nxt;
      sv_lap_r    <= sv_lap_nxt;
      failed_r    <= failed_nxt;
    end
    cmd_r  <= cmd_nxt;
    port_r <= port_nxt;
    data_r <= data_nxt;
    slot_r <= slot_nxt;
    skip_r <= skip_nxt;
    red_r  <= red_nxt;
    walk_r <= walk_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.overrun, out_r.unexpected_byte, out_r.reply_data,
                       out_r.reply_valid, out_r.slot_index};
  assign out_tuser  = out_r.status;

  // checks
  `RSRM_ASSERT_NXT(a_accept_dispatch, in_tvalid && in_tready, state_r == ST_DISP, "accepted transfer not dispatched")
  `RSRM_ASSERT_IMP(a_walk_no_collision, ram_we && (state_r == ST_RX_CHK || state_r == ST_RSY_CHK || state_r == ST_CAN_CHK), ram_waddr != ram_raddr, "tag read and write collide in a walk")
  `RSRM_ASSERT_IMP(a_skip_bound, state_r == ST_RX_CHK, int'(skip_r) < RING_DEPTH, "skip walk ran past one lap")
  `RSRM_ASSERT_IMP(a_reply_consistent, out_tvalid && out_tdata[7], (out_tuser == STAT_OK) && !out_tdata[16], "reply with bad status or unexpected flag")

endmodule
